>>> sv/multilook_box_average_assert.svh
// Assertion macros shared by the multilook box average RTL.
`ifndef MULTILOOK_BOX_AVERAGE_ASSERT_SVH
`define MULTILOOK_BOX_AVERAGE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MBA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define MBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define MBA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/mba_pkg.sv
// Package with constants, types and tables of the multilook box average.
package mba_pkg;

    localparam int MAX_OUT_COLS = 1024;
    localparam int NUM_CHANNELS = 4;
    localparam int MAX_LOOKS    = 16;
    localparam int SAMPLE_BITS  = 32;
    localparam int CHAN_BITS    = 32;
    localparam int SUM_BITS     = 40;
    localparam int COL_AW       = $clog2(MAX_OUT_COLS);
    localparam int DIV_BITS     = $clog2(MAX_LOOKS * MAX_LOOKS + 1);
    localparam int CNT_BITS     = $clog2(SUM_BITS);
    localparam int RECIP_SHIFT  = 21;
    localparam int RECIP_BITS   = RECIP_SHIFT + 1;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_ROWS   = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_COLS   = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_ROWS      = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_COLS      = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOK_ROWS     = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOK_COLS     = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_COLS    = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 4'd7;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [COL_AW-1:0]   addr;
        logic                first;
        logic                div_start;
        logic [DIV_BITS-1:0] divisor;
    } lane_ctrl_t;

    typedef struct packed {
        logic                 busy;
        logic [CHAN_BITS-1:0] quot;
    } lane_stat_t;

    // Floor of 2^21 / lc, so that (rel * recip) >> 21 is the quotient or one short.
    function automatic logic [RECIP_BITS-1:0] recip(input logic [4:0] lc);
        logic [RECIP_BITS-1:0] r;
        case (lc)
            5'd1:    r = 22'd2097152;
            5'd2:    r = 22'd1048576;
            5'd3:    r = 22'd699050;
            5'd4:    r = 22'd524288;
            5'd5:    r = 22'd419430;
            5'd6:    r = 22'd349525;
            5'd7:    r = 22'd299593;
            5'd8:    r = 22'd262144;
            5'd9:    r = 22'd233016;
            5'd10:   r = 22'd209715;
            5'd11:   r = 22'd190650;
            5'd12:   r = 22'd174762;
            5'd13:   r = 22'd161319;
            5'd14:   r = 22'd149796;
            5'd15:   r = 22'd139810;
            5'd16:   r = 22'd131072;
            default: r = 22'd2097152;
        endcase
        return r;
    endfunction

endpackage

>>> sv/mba_if.sv
// Channel interfaces: pixel input, averaged result output and register writes.
interface mba_pix_if;
    logic                           valid;
    logic                           ready;
    logic [mba_pkg::CHAN_BITS-1:0]  chan_a;
    logic [mba_pkg::CHAN_BITS-1:0]  chan_b;
    logic [mba_pkg::CHAN_BITS-1:0]  chan_c;
    logic [mba_pkg::CHAN_BITS-1:0]  chan_d;
    modport source (output valid, output chan_a, output chan_b, output chan_c,
                    output chan_d, input ready);
    modport sink (input valid, input chan_a, input chan_b, input chan_c,
                  input chan_d, output ready);
endinterface

interface mba_res_if;
    logic                           valid;
    logic                           ready;
    logic [mba_pkg::CHAN_BITS-1:0]  avg_a;
    logic [mba_pkg::CHAN_BITS-1:0]  avg_b;
    logic [mba_pkg::CHAN_BITS-1:0]  avg_c;
    logic [mba_pkg::CHAN_BITS-1:0]  avg_d;
    logic                           row_end;
    logic                           frame_end;
    modport source (output valid, output avg_a, output avg_b, output avg_c,
                    output avg_d, output row_end, output frame_end, input ready);
    modport sink (input valid, input avg_a, input avg_b, input avg_c,
                  input avg_d, input row_end, input frame_end, output ready);
endinterface

interface mba_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mba_pkg::CFG_IDX_BITS-1:0]   index;
    logic [mba_pkg::CFG_DATA_BITS-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/mba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mba_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/mba_lane.sv
// One channel lane: column accumulator memory and an iterative divider.
module mba_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mba_pkg::lane_ctrl_t               ctrl,
    input  logic [mba_pkg::CHAN_BITS-1:0]     sample,
    output mba_pkg::lane_stat_t               stat
);

    logic [mba_pkg::SUM_BITS-1:0]   rd_data;
    logic [mba_pkg::SUM_BITS-1:0]   samp_ext;
    logic [mba_pkg::SUM_BITS-1:0]   sum_new;
    logic [mba_pkg::SUM_BITS-1:0]   dvd_reg;
    logic [mba_pkg::DIV_BITS-1:0]   rem_reg;
    logic [mba_pkg::DIV_BITS-1:0]   div_reg;
    logic [mba_pkg::CNT_BITS-1:0]   cnt_reg;
    logic                           busy_reg;
    logic [mba_pkg::DIV_BITS:0]     trial;
    logic                           q_bit;

    assign samp_ext = mba_pkg::SUM_BITS'(sample[mba_pkg::SAMPLE_BITS-1:0]);
    assign sum_new  = ctrl.first ? samp_ext : rd_data + samp_ext;

    mba_ram #(
        .WIDTH (mba_pkg::SUM_BITS),
        .DEPTH (mba_pkg::MAX_OUT_COLS)
    ) u_sums (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (ctrl.addr),
        .wr_data (sum_new),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ctrl.addr),
        .rd_data (rd_data)
    );

    // Restoring division, one quotient bit a cycle; quotient bits shift into dvd_reg.
    assign trial = {rem_reg, dvd_reg[mba_pkg::SUM_BITS-1]};
    assign q_bit = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == mba_pkg::CNT_BITS'(mba_pkg::SUM_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            dvd_reg <= sum_new;
            rem_reg <= '0;
            div_reg <= ctrl.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[mba_pkg::SUM_BITS-2:0], q_bit};
            rem_reg <= q_bit ? mba_pkg::DIV_BITS'(trial - {1'b0, div_reg})
                             : trial[mba_pkg::DIV_BITS-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.quot = dvd_reg[mba_pkg::CHAN_BITS-1:0];

endmodule

>>> sv/multilook_box_average.sv
// Top level of the multilook box average: position control, lanes and result merge.
//
// Pixels enter in raster order on the pix channel, one beat per pixel, each with
// four unsigned Q16.16 channel intensities. Registers are written through the cfg
// channel (index 0..7 in the order offset_rows, offset_cols, out_rows, out_cols,
// look_rows, look_cols, image_cols, channel_count); it is always ready and must
// only be used while no pixel is in flight.
// A pixel outside the crop passes through S_QUOT and S_FIX back to S_IDLE, and a
// pixel that is accumulated also passes S_READ and S_ACC: a reciprocal multiply
// finds the block column, then a read-modify-write of the per-column accumulator
// memory in every enabled lane. A pixel that closes a block adds the bit-serial
// divide by look_rows*look_cols, one quotient bit a cycle, and then the load of
// the output register, which waits until the receiver has taken an earlier result;
// the next pixel can be accepted in the same cycle that its result appears on res.
// The res channel is held in an output register: the next pixel is accepted while
// a result waits, and only a second finished result waits for the receiver.
// Reset returns the configuration registers, raster position and state to their
// defaults and drops res.valid; the datapath registers are not reset and the
// accumulator memory is not cleared, since the first pixel of every block overwrites it.
module multilook_box_average (
    input  logic       clk,
    input  logic       rst_n,
    mba_pix_if.sink    pix,
    mba_res_if.source  res,
    mba_cfg_if.sink    cfg
);

    `include "multilook_box_average_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUOT,
        S_FIX,
        S_READ,
        S_ACC,
        S_DIVIDE
    } state_t;

    localparam int NCH = mba_pkg::NUM_CHANNELS;
    localparam int PROD_BITS = 16 + mba_pkg::RECIP_BITS;

    state_t state_reg;

    // Configuration registers.
    logic [15:0] offset_rows_reg;
    logic [15:0] offset_cols_reg;
    logic [15:0] out_rows_reg;
    logic [10:0] out_cols_reg;
    logic [4:0]  look_rows_reg;
    logic [4:0]  look_cols_reg;
    logic [15:0] image_cols_reg;
    logic [2:0]  channel_count_reg;

    // Effective, clamped register values.
    logic [4:0]  lr;
    logic [4:0]  lc;
    logic [10:0] oc;
    logic [15:0] orows;
    logic [15:0] ic;
    logic [2:0]  nch;

    // Raster position.
    logic [15:0] input_row_reg;
    logic [15:0] input_col_reg;
    logic [3:0]  look_idx_reg;
    logic [15:0] out_row_cnt_reg;

    logic active;
    logic last_look_row;
    logic row_last;

    // Per-pixel working registers.
    logic [mba_pkg::CHAN_BITS-1:0] samp_reg [NCH];
    logic                    crop_reg;
    logic                    first_row_reg;
    logic                    last_look_reg;
    logic                    last_orow_reg;
    logic [15:0]             rel_reg;
    logic [PROD_BITS-1:0]    prod_reg;
    logic [15:0]             j0_reg;
    logic [16:0]             r0_reg;
    logic [15:0]             j_reg;
    logic                    first_reg;
    logic                    emit_reg;
    logic                    rend_reg;
    logic                    fend_reg;

    logic [15:0] rel_now;
    logic [15:0] j_fix;
    logic [16:0] jj_fix;
    logic        hit_fix;

    mba_pkg::lane_ctrl_t lane_ctrl [NCH];
    mba_pkg::lane_stat_t lane_stat [NCH];
    logic [NCH-1:0]      lane_busy;
    logic                busy_any;

    // Output register.
    logic                          res_valid_reg;
    logic [mba_pkg::CHAN_BITS-1:0] avg_reg [NCH];
    logic                          row_end_reg;
    logic                          frame_end_reg;
    logic                          res_free;
    logic                          res_load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_rows_reg   <= 16'd0;
            offset_cols_reg   <= 16'd0;
            out_rows_reg      <= 16'd1;
            out_cols_reg      <= 11'd1;
            look_rows_reg     <= 5'd1;
            look_cols_reg     <= 5'd1;
            image_cols_reg    <= 16'd1;
            channel_count_reg <= 3'd2;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mba_pkg::REG_OFFSET_ROWS:   offset_rows_reg   <= cfg.data;
                mba_pkg::REG_OFFSET_COLS:   offset_cols_reg   <= cfg.data;
                mba_pkg::REG_OUT_ROWS:      out_rows_reg      <= cfg.data;
                mba_pkg::REG_OUT_COLS:      out_cols_reg      <= cfg.data[10:0];
                mba_pkg::REG_LOOK_ROWS:     look_rows_reg     <= cfg.data[4:0];
                mba_pkg::REG_LOOK_COLS:     look_cols_reg     <= cfg.data[4:0];
                mba_pkg::REG_IMAGE_COLS:    image_cols_reg    <= cfg.data;
                mba_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg.data[2:0];
                default:                    ;
            endcase
        end
    end

    // Out-of-range register values are clamped to the nearest legal value.
    always_comb
    begin
        lr = (look_rows_reg == 5'd0) ? 5'd1 :
             (look_rows_reg > 5'(mba_pkg::MAX_LOOKS)) ? 5'(mba_pkg::MAX_LOOKS) : look_rows_reg;
        lc = (look_cols_reg == 5'd0) ? 5'd1 :
             (look_cols_reg > 5'(mba_pkg::MAX_LOOKS)) ? 5'(mba_pkg::MAX_LOOKS) : look_cols_reg;
        oc = (out_cols_reg == 11'd0) ? 11'd1 :
             (out_cols_reg > 11'(mba_pkg::MAX_OUT_COLS)) ? 11'(mba_pkg::MAX_OUT_COLS)
                                                         : out_cols_reg;
        orows = (out_rows_reg == 16'd0) ? 16'd1 : out_rows_reg;
        ic    = (image_cols_reg == 16'd0) ? 16'd1 : image_cols_reg;
        nch = (channel_count_reg < 3'd2) ? 3'd2 :
              (channel_count_reg > 3'(NCH)) ? 3'(NCH) : channel_count_reg;
    end

    assign active        = (input_row_reg >= offset_rows_reg) && (out_row_cnt_reg < orows);
    assign last_look_row = ({1'b0, look_idx_reg} + 5'd1) >= lr;
    assign row_last      = ({1'b0, input_col_reg} + 17'd1) >= {1'b0, ic};
    assign rel_now       = input_col_reg - offset_cols_reg;

    // The reciprocal estimate of the block column is at most one short; fix it up.
    always_comb
    begin
        if (r0_reg >= 17'(lc))
        begin
            j_fix  = j0_reg + 16'd1;
            jj_fix = r0_reg - 17'(lc);
        end
        else
        begin
            j_fix  = j0_reg;
            jj_fix = r0_reg;
        end
        hit_fix = crop_reg && (j_fix < 16'(oc));
    end

    assign pix.ready = (state_reg == S_IDLE);
    assign res_free  = !res_valid_reg || res.ready;
    assign res_load  = (state_reg == S_DIVIDE) && !busy_any && res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            input_row_reg   <= 16'd0;
            input_col_reg   <= 16'd0;
            look_idx_reg    <= 4'd0;
            out_row_cnt_reg <= 16'd0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pix.valid)
                    begin
                        state_reg <= S_QUOT;
                        if (row_last)
                        begin
                            input_col_reg <= 16'd0;
                            if (active)
                            begin
                                if (last_look_row)
                                begin
                                    look_idx_reg    <= 4'd0;
                                    out_row_cnt_reg <= out_row_cnt_reg + 16'd1;
                                end
                                else
                                begin
                                    look_idx_reg <= look_idx_reg + 4'd1;
                                end
                            end
                            if (input_row_reg != 16'hFFFF)
                            begin
                                input_row_reg <= input_row_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            input_col_reg <= input_col_reg + 16'd1;
                        end
                    end
                end
                S_QUOT:
                begin
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    state_reg <= hit_fix ? S_READ : S_IDLE;
                end
                S_READ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= emit_reg ? S_DIVIDE : S_IDLE;
                end
                S_DIVIDE:
                begin
                    if (res_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the pixel being worked on and of the result.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pix.valid)
        begin
            samp_reg[0]   <= pix.chan_a;
            samp_reg[1]   <= pix.chan_b;
            samp_reg[2]   <= pix.chan_c;
            samp_reg[3]   <= pix.chan_d;
            crop_reg      <= active && (input_col_reg >= offset_cols_reg);
            first_row_reg <= (look_idx_reg == 4'd0);
            last_look_reg <= last_look_row;
            last_orow_reg <= ({1'b0, out_row_cnt_reg} + 17'd1) == {1'b0, orows};
            rel_reg       <= rel_now;
            prod_reg      <= PROD_BITS'(rel_now) * PROD_BITS'(mba_pkg::recip(lc));
        end
        if (state_reg == S_QUOT)
        begin
            j0_reg <= prod_reg[mba_pkg::RECIP_SHIFT +: 16];
            r0_reg <= 17'(rel_reg) - 17'(prod_reg[mba_pkg::RECIP_SHIFT +: 16] * 16'(lc));
        end
        if (state_reg == S_FIX)
        begin
            j_reg     <= j_fix;
            first_reg <= first_row_reg && (jj_fix == 17'd0);
            emit_reg  <= last_look_reg && ((jj_fix + 17'd1) == 17'(lc));
            rend_reg  <= (j_fix + 16'd1) == 16'(oc);
            fend_reg  <= ((j_fix + 16'd1) == 16'(oc)) && last_orow_reg;
        end
        if (res_load)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                avg_reg[k] <= (3'(k) < nch) ? lane_stat[k].quot : '0;
            end
            row_end_reg   <= rend_reg;
            frame_end_reg <= fend_reg;
        end
    end

    // Lanes: one per channel, each with its own accumulator memory and divider.
    for (genvar g = 0; g < NCH; g++)
    begin : g_lane
        always_comb
        begin
            lane_ctrl[g].rd_en     = (state_reg == S_READ);
            lane_ctrl[g].wr_en     = (state_reg == S_ACC) && (3'(g) < nch);
            lane_ctrl[g].addr      = j_reg[mba_pkg::COL_AW-1:0];
            lane_ctrl[g].first     = first_reg;
            lane_ctrl[g].div_start = (state_reg == S_ACC) && emit_reg;
            lane_ctrl[g].divisor   = mba_pkg::DIV_BITS'(lr) * mba_pkg::DIV_BITS'(lc);
        end

        mba_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl[g]),
            .sample (samp_reg[g]),
            .stat   (lane_stat[g])
        );

        assign lane_busy[g] = lane_stat[g].busy;
    end

    assign busy_any = |lane_busy;

    assign res.valid     = res_valid_reg;
    assign res.avg_a     = avg_reg[0];
    assign res.avg_b     = avg_reg[1];
    assign res.avg_c     = avg_reg[2];
    assign res.avg_d     = avg_reg[3];
    assign res.row_end   = row_end_reg;
    assign res.frame_end = frame_end_reg;

    // The last output of the image always closes an output row.
    `MBA_ASSERT_IMPLIES(a_frame_has_row_end, clk, rst_n, res_valid_reg && frame_end_reg, row_end_reg)
    // The dividers only run while the controller waits for them.
    `MBA_ASSERT_IMPLIES(a_busy_in_divide, clk, rst_n, busy_any, state_reg == S_DIVIDE)
    // A new result only comes out of the divide state.
    `MBA_ASSERT_IMPLIES(a_result_from_divide, clk, rst_n, $rose(res_valid_reg), $past(state_reg == S_DIVIDE))

endmodule
